// ===== design/nrmc_pkg.sv =====
// Shared types, character codes and lookup functions for the NMEA RMC sentence checker.
package nrmc_pkg;

	typedef struct packed {
		logic [7:0] sentence_byte;
		logic       end_of_sentence;
	} sent_beat_t;

	typedef struct packed {
		logic       checksum_ok;
		logic       is_rmc;
		logic       time_updated;
		logic [7:0] hours;
		logic [7:0] minutes;
		logic [7:0] seconds;
	} stat_beat_t;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;

	localparam int unsigned HEADER_LEN = 6;
	localparam int unsigned TIME_LEN   = 6;
	localparam int unsigned HEX_LEN    = 2;

	// "$GPRMC"
	function automatic logic [7:0] header_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = CHAR_DOLLAR;
			3'd1:    c = 8'h47;
			3'd2:    c = 8'h50;
			3'd3:    c = 8'h52;
			3'd4:    c = 8'h4D;
			3'd5:    c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// uppercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CHAR_ZERO + {4'd0, nib};
		end else begin
			c = CHAR_UPPER_A + {4'd0, nib} - 8'd10;
		end
		return c;
	endfunction

	// (a-48)*10 + (b-48), mod 256
	function automatic logic [7:0] digit_pair(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] da;
		logic [7:0] db;
		da = a - CHAR_ZERO;
		db = b - CHAR_ZERO;
		return (da << 3) + (da << 1) + db;
	endfunction

endpackage

// ===== design/nmea_rmc_checksum_time_parser_top.sv =====
// Top level of the NMEA RMC sentence checksum checker and UTC time extractor.
//
//   channel   beat          handshake              direction
//   sent      sent_beat_t   sent_valid/sent_stall  in: one sentence character
//   stat      stat_beat_t   stat_valid/stat_stall  out: one status per sentence
//
// One character per cycle unless sent_stall holds it: input register, one pass of
// compare/XOR/counter logic, then the status register that holds each sentence's status.
// arst_n clears the counters, flags, XOR sum and stored time; the header flag resets to one.
// sent_stall rises only while a final character waits on a stalled status beat.
module nmea_rmc_checksum_time_parser_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sent_valid,
	output logic                sent_stall,
	input  nrmc_pkg::sent_beat_t sent_beat,
	output logic                stat_valid,
	input  logic                stat_stall,
	output nrmc_pkg::stat_beat_t stat_beat
);
	import nrmc_pkg::*;

	logic       valid_s1;
	sent_beat_t beat_s1;
	logic       process;

	logic [2:0]  pos_q,   n_pos;
	logic        hdr_q,   n_hdr;
	logic        dollar_q, n_dollar;
	logic [7:0]  xor_q,   n_xor;
	logic        star_q,  n_star;
	logic [1:0]  hcnt_q,  n_hcnt;
	logic [7:0]  hex_q  [HEX_LEN];
	logic [7:0]  n_hex  [HEX_LEN];
	logic [1:0]  dcnt_q,  n_dcnt;
	logic [7:0]  tch_q  [TIME_LEN];
	logic [7:0]  n_tch  [TIME_LEN];
	logic [2:0]  tcnt_q,  n_tcnt;
	logic [23:0] time_q,  n_time;

	logic       b_delim;
	logic [7:0] b;
	logic       ok, rmc, upd;

	stat_beat_t stat_q;
	logic       stat_valid_q;

	assign process    = valid_s1 && !(beat_s1.end_of_sentence && stat_valid_q && stat_stall);
	assign sent_stall = valid_s1 && !process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sent_valid && !sent_stall) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sent_valid && !sent_stall) begin
			beat_s1 <= sent_beat;
		end
	end

	always_comb begin
		b       = beat_s1.sentence_byte;
		b_delim = (b == CHAR_COMMA) || (b == CHAR_STAR);
		n_pos    = pos_q;
		n_hdr    = hdr_q;
		n_dollar = dollar_q;
		n_xor    = xor_q;
		n_star   = star_q;
		n_hcnt   = hcnt_q;
		n_hex    = hex_q;
		n_dcnt   = dcnt_q;
		n_tch    = tch_q;
		n_tcnt   = tcnt_q;

		if (pos_q == 3'd0) begin
			n_dollar = (b == CHAR_DOLLAR);
		end else if (!star_q) begin
			if (b == CHAR_STAR) begin
				n_star = 1'b1;
			end else begin
				n_xor = xor_q ^ b;
			end
		end else if (hcnt_q < 2'(HEX_LEN)) begin
			n_hex[hcnt_q[0]] = b;
			n_hcnt = hcnt_q + 2'd1;
		end

		if ((pos_q < 3'(HEADER_LEN)) && (b != header_char(pos_q))) begin
			n_hdr = 1'b0;
		end

		if (dcnt_q == 2'd0) begin
			if (b_delim) begin
				n_dcnt = 2'd1;
			end
		end else if (b_delim || (b == CHAR_CR)) begin
			if (dcnt_q != 2'd3) begin
				n_dcnt = dcnt_q + 2'd1;
			end
		end else if ((dcnt_q == 2'd1) && (tcnt_q < 3'(TIME_LEN))) begin
			n_tch[tcnt_q] = b;
			n_tcnt = tcnt_q + 3'd1;
		end

		if (pos_q != 3'd7) begin
			n_pos = pos_q + 3'd1;
		end

		ok  = n_dollar && n_star && (n_hcnt == 2'(HEX_LEN)) &&
		      (n_hex[0] == hex_char(n_xor[7:4])) && (n_hex[1] == hex_char(n_xor[3:0]));
		rmc = ok && n_hdr && (n_pos >= 3'(HEADER_LEN));
		upd = rmc && (n_tcnt == 3'(TIME_LEN)) &&
		      (n_tch[0] >= CHAR_ZERO) && (n_tch[0] <= CHAR_NINE);

		n_time = time_q;
		if (upd) begin
			n_time = {digit_pair(n_tch[0], n_tch[1]),
			          digit_pair(n_tch[2], n_tch[3]),
			          digit_pair(n_tch[4], n_tch[5])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hdr_q    <= 1'b1;
			dollar_q <= 1'b0;
			xor_q    <= '0;
			star_q   <= 1'b0;
			hcnt_q   <= '0;
			dcnt_q   <= '0;
			tcnt_q   <= '0;
			time_q   <= '0;
		end else if (process) begin
			time_q <= n_time;
			if (beat_s1.end_of_sentence) begin
				pos_q    <= '0;
				hdr_q    <= 1'b1;
				dollar_q <= 1'b0;
				xor_q    <= '0;
				star_q   <= 1'b0;
				hcnt_q   <= '0;
				dcnt_q   <= '0;
				tcnt_q   <= '0;
			end else begin
				pos_q    <= n_pos;
				hdr_q    <= n_hdr;
				dollar_q <= n_dollar;
				xor_q    <= n_xor;
				star_q   <= n_star;
				hcnt_q   <= n_hcnt;
				dcnt_q   <= n_dcnt;
				tcnt_q   <= n_tcnt;
			end
		end
	end

	// character stores, guarded by their counts
	always_ff @(posedge clk) begin
		if (process) begin
			hex_q <= n_hex;
			tch_q <= n_tch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_valid_q <= 1'b0;
		end else if (process && beat_s1.end_of_sentence) begin
			stat_valid_q <= 1'b1;
		end else if (!stat_stall) begin
			stat_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && beat_s1.end_of_sentence) begin
			stat_q.checksum_ok  <= ok;
			stat_q.is_rmc       <= rmc;
			stat_q.time_updated <= upd;
			stat_q.hours        <= n_time[23:16];
			stat_q.minutes      <= n_time[15:8];
			stat_q.seconds      <= n_time[7:0];
		end
	end

	assign stat_valid = stat_valid_q;
	assign stat_beat  = stat_q;

endmodule

// ===== design/nrmc_chk.sv =====
// Port-level assertions for the NMEA RMC sentence checker, bound to the top level.
module nrmc_chk (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sent_valid,
	input logic                 sent_stall,
	input nrmc_pkg::sent_beat_t sent_beat,
	input logic                 stat_valid,
	input logic                 stat_stall,
	input nrmc_pkg::stat_beat_t stat_beat
);
	import nrmc_pkg::*;

	a_stat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid && stat_stall |=> stat_valid && $stable(stat_beat))
		else $error("status beat dropped or changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sent_stall |-> stat_valid && stat_stall)
		else $error("input stalled without a blocked status beat");

	a_rmc_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid && stat_beat.is_rmc |-> stat_beat.checksum_ok)
		else $error("RMC flagged without a good checksum");

	a_upd_needs_rmc: assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid && stat_beat.time_updated |-> stat_beat.is_rmc)
		else $error("time updated by a sentence that is not RMC");

endmodule

bind nmea_rmc_checksum_time_parser_top nrmc_chk u_nrmc_chk (.*);

// ===== tb/tb_nmea_rmc_checksum_time_parser_top.sv =====
// Self-checking testbench for the NMEA RMC checksum and UTC time parser.
`timescale 1ns / 100ps

module tb_nmea_rmc_checksum_time_parser_top;
	import nrmc_pkg::*;

	localparam int CYCLE_LIMIT = 400_000;
	localparam logic [47:0]  RMC_HEADER = "$GPRMC";
	localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";
	localparam logic [7:0]   CHAR_LF = 8'h0A;
	localparam logic [7:0]   CASE_BIT = 8'h20;

	typedef enum int {SUM_GOOD, SUM_LOWER, SUM_WRONG, SUM_ONE, SUM_NONE} sum_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       sent_valid = 1'b0;
	logic       sent_stall;
	sent_beat_t sent_beat = '0;
	logic       stat_valid;
	logic       stat_stall = 1'b0;
	stat_beat_t stat_beat;

	nmea_rmc_checksum_time_parser_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sent_valid (sent_valid),
		.sent_stall (sent_stall),
		.sent_beat  (sent_beat),
		.stat_valid (stat_valid),
		.stat_stall (stat_stall),
		.stat_beat  (stat_beat)
	);

	always #5 clk = ~clk;

	// parser state as the testbench sees it
	logic [2:0] col;
	logic       hdr_ok;
	logic       lead_dollar;
	logic [7:0] xsum;
	logic       star_hit;
	logic [1:0] hex_n;
	logic [7:0] hex_got [2];
	logic [1:0] field_n;
	logic [7:0] time_got [6];
	logic [2:0] time_n;
	logic [7:0] utc_hh = 8'd0;
	logic [7:0] utc_mm = 8'd0;
	logic [7:0] utc_ss = 8'd0;

	stat_beat_t pending_status [$];
	logic [7:0] line_q [$];

	string      row_head [$];
	bit         row_sum [$];
	string      row_tail [$];
	bit         row_typed [$];
	stat_beat_t row_exp [$];

	bit         idle_in = 1'b0;
	bit         idle_out = 1'b0;
	int         stall_wait = 0;
	logic       stall_next = 1'b0;
	int         errors = 0;
	int         cycles = 0;
	int         chars_sent = 0;
	int         lines_sent = 0;
	int         results = 0;
	int         updates = 0;
	stat_beat_t want;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		return HEX_DIGITS[8 * (15 - int'(nib)) +: 8];
	endfunction

	function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] t;
		t = (a - CHAR_ZERO) * 8'd10 + (b - CHAR_ZERO);
		return t;
	endfunction

	task automatic restart_sentence();
		col = 3'd0;
		hdr_ok = 1'b1;
		lead_dollar = 1'b0;
		xsum = 8'd0;
		star_hit = 1'b0;
		hex_n = 2'd0;
		hex_got[0] = 8'd0;
		hex_got[1] = 8'd0;
		field_n = 2'd0;
		for (int i = 0; i < 6; i++) time_got[i] = 8'd0;
		time_n = 3'd0;
	endtask

	task automatic parse_char(input sent_beat_t b, output bit done, output stat_beat_t st);
		logic [7:0] c;
		logic       delim;
		logic       ok;
		logic       rmc;
		logic       upd;
		c = b.sentence_byte;
		delim = (c == CHAR_COMMA) || (c == CHAR_STAR);
		if (col == 3'd0) begin
			lead_dollar = (c == CHAR_DOLLAR);
		end else if (!star_hit) begin
			if (c == CHAR_STAR) star_hit = 1'b1;
			else xsum ^= c;
		end else if (hex_n < 2'd2) begin
			hex_got[hex_n[0]] = c;
			hex_n++;
		end
		if (col < 3'd6 && c != RMC_HEADER[8 * (5 - int'(col)) +: 8]) hdr_ok = 1'b0;
		if (field_n == 2'd0) begin
			if (delim) field_n = 2'd1;
		end else if (delim || c == CHAR_CR) begin
			if (field_n < 2'd3) field_n++;
		end else if (field_n == 2'd1 && time_n < 3'd6) begin
			time_got[time_n] = c;
			time_n++;
		end
		if (col < 3'd7) col++;
		done = b.end_of_sentence;
		st = '0;
		if (done) begin
			ok = lead_dollar && star_hit && hex_n == 2'd2 &&
				hex_got[0] == hex_digit(xsum[7:4]) && hex_got[1] == hex_digit(xsum[3:0]);
			rmc = ok && hdr_ok && col >= 3'd6;
			upd = rmc && time_n == 3'd6 && time_got[0] >= CHAR_ZERO && time_got[0] <= CHAR_NINE;
			if (upd) begin
				utc_hh = pair_value(time_got[0], time_got[1]);
				utc_mm = pair_value(time_got[2], time_got[3]);
				utc_ss = pair_value(time_got[4], time_got[5]);
			end
			st.checksum_ok = ok;
			st.is_rmc = rmc;
			st.time_updated = upd;
			st.hours = utc_hh;
			st.minutes = utc_mm;
			st.seconds = utc_ss;
			restart_sentence();
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("status %0d: %s is %0d, expected %0d", results, what, got, exp_val);
		errors++;
	endtask

	// beat sent at a rising edge; returns at the edge that takes it
	task automatic send_char(input sent_beat_t b, input bit typed, input stat_beat_t exp_st);
		int         gap;
		bit         done;
		stat_beat_t st;
		gap = idle_in ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			sent_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sent_valid <= 1'b1;
		sent_beat <= b;
		@(negedge clk);
		while (sent_stall) @(negedge clk);
		@(posedge clk);
		chars_sent++;
		parse_char(b, done, st);
		if (done) pending_status.push_back(typed ? exp_st : st);
	endtask

	task automatic send_line(input bit typed, input stat_beat_t exp_st);
		sent_beat_t b;
		idle_in = $urandom_range(0, 3) != 0;
		idle_out = $urandom_range(0, 3) != 0;
		for (int i = 0; i < line_q.size(); i++) begin
			b.sentence_byte = line_q[i];
			b.end_of_sentence = (i == line_q.size() - 1);
			send_char(b, typed, exp_st);
		end
		lines_sent++;
	endtask

	task automatic drain_status();
		sent_valid <= 1'b0;
		do @(posedge clk); while (pending_status.size() != 0);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endtask

	task automatic close_sum(input sum_mode_t mode);
		logic [7:0] x;
		logic [7:0] hi;
		logic [7:0] lo;
		x = 8'd0;
		for (int i = 1; i < line_q.size(); i++) x ^= line_q[i];
		if (mode == SUM_NONE) return;
		if (mode == SUM_WRONG) x ^= 8'($urandom_range(1, 255));
		hi = hex_digit(x[7:4]);
		lo = hex_digit(x[3:0]);
		if (mode == SUM_LOWER) begin
			if (hi >= CHAR_UPPER_A) hi |= CASE_BIT;
			if (lo >= CHAR_UPPER_A) lo |= CASE_BIT;
		end
		line_q.push_back(CHAR_STAR);
		line_q.push_back(hi);
		if (mode != SUM_ONE) line_q.push_back(lo);
	endtask

	function automatic logic [7:0] field_char(input int lo, input int hi);
		logic [7:0] c;
		do c = 8'($urandom_range(hi, lo));
		while (c == CHAR_COMMA || c == CHAR_STAR || c == CHAR_CR);
		return c;
	endfunction

	task automatic push_digits(input int n);
		repeat (n) line_q.push_back(field_char(CHAR_ZERO, CHAR_NINE));
	endtask

	task automatic push_time();
		int         k;
		int         v;
		logic [7:0] c;
		k = $urandom_range(0, 99);
		if (k < 55) begin
			repeat (3) begin
				v = $urandom_range(0, 99);
				line_q.push_back(CHAR_ZERO + 8'(v / 10));
				line_q.push_back(CHAR_ZERO + 8'(v % 10));
			end
			if ($urandom_range(0, 1)) push_text(".00");
		end else if (k < 65) begin
			push_digits(1);
			repeat (5) line_q.push_back(field_char(0, 255));
		end else if (k < 75) begin
			case ($urandom_range(0, 2))
				0: c = CHAR_ZERO - 8'd1;
				1: c = CHAR_NINE + 8'd1;
				default: begin
					do c = field_char(0, 255);
					while (c >= CHAR_ZERO && c <= CHAR_NINE);
				end
			endcase
			line_q.push_back(c);
			push_digits(5);
		end else if (k < 88) begin
			push_digits($urandom_range(0, 5));
			if ($urandom_range(0, 1)) begin
				line_q.push_back(CHAR_CR);
				push_digits(3);
			end
		end else begin
			push_digits($urandom_range(7, 12));
		end
	endtask

	task automatic push_fields(input int n);
		repeat (n) begin
			line_q.push_back(CHAR_COMMA);
			repeat ($urandom_range(0, 8)) line_q.push_back(field_char(32, 126));
		end
	endtask

	task automatic make_sentence();
		int        kind;
		sum_mode_t mode;
		line_q.delete();
		kind = $urandom_range(0, 99);
		if (kind >= 85) begin
			repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1)) line_q[0] = CHAR_DOLLAR;
			return;
		end
		mode = SUM_GOOD;
		line_q.push_back(CHAR_DOLLAR);
		if (kind >= 55 && kind < 65) begin
			repeat (5) line_q.push_back(CHAR_UPPER_A + 8'($urandom_range(0, 25)));
			if ($urandom_range(0, 3) == 0) line_q[$urandom_range(1, 5)] = CHAR_CR;
		end else begin
			push_text("GPRMC");
		end
		if (kind >= 75 && kind < 80) begin
			// field 1 opens at the checksum star
			close_sum(SUM_GOOD);
			push_digits($urandom_range(4, 8));
		end else begin
			line_q.push_back(CHAR_COMMA);
			push_time();
			push_fields(kind >= 80 ? $urandom_range(8, 12) : $urandom_range(0, 4));
			if (kind >= 65 && kind < 75) mode = sum_mode_t'($urandom_range(SUM_LOWER, SUM_NONE));
			close_sum(mode);
		end
		if (mode != SUM_ONE) begin
			case ($urandom_range(0, 3))
				1: begin
					line_q.push_back(CHAR_CR);
					line_q.push_back(CHAR_LF);
				end
				2: repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
				default: ;
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
	endtask

	task automatic add_row(input string head, input bit with_sum, input string tail,
		input bit typed, input stat_beat_t exp_st);
		row_head.push_back(head);
		row_sum.push_back(with_sum);
		row_tail.push_back(tail);
		row_typed.push_back(typed);
		row_exp.push_back(exp_st);
	endtask

	always @(posedge clk) begin
		stat_stall <= stall_next;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d status beats pending", cycles,
				pending_status.size());
			$display("[nmea_rmc_checksum_time_parser_top] ERROR");
			$finish;
		end
	end

	// status beat is taken at the next rising edge when valid and not stalled here
	always @(negedge clk) begin
		if (arst_n) begin
			if (stat_valid && !stat_stall) begin
				if (pending_status.size() == 0) begin
					report_mismatch("unexpected beat", 1, 0);
				end else begin
					want = pending_status.pop_front();
					if (stat_beat.checksum_ok != want.checksum_ok)
						report_mismatch("checksum_ok", stat_beat.checksum_ok, want.checksum_ok);
					if (stat_beat.is_rmc != want.is_rmc)
						report_mismatch("is_rmc", stat_beat.is_rmc, want.is_rmc);
					if (stat_beat.time_updated != want.time_updated)
						report_mismatch("time_updated", stat_beat.time_updated,
							want.time_updated);
					if (stat_beat.hours != want.hours)
						report_mismatch("hours", stat_beat.hours, want.hours);
					if (stat_beat.minutes != want.minutes)
						report_mismatch("minutes", stat_beat.minutes, want.minutes);
					if (stat_beat.seconds != want.seconds)
						report_mismatch("seconds", stat_beat.seconds, want.seconds);
				end
				results++;
				if (stat_beat.time_updated) updates++;
				stall_wait = idle_out ? $urandom_range(0, 8) : 0;
			end else if (stat_valid && stall_wait > 0) begin
				stall_wait--;
			end
			stall_next = (stall_wait > 0);
		end
	end

	initial begin
		int random_lines;
		restart_sentence();
		random_lines = 0;

		add_row("$*00", 1'b0, "", 1'b1, {1'b1, 1'b0, 1'b0, 24'd0});
		add_row("$*0", 1'b0, "", 1'b1, {1'b0, 1'b0, 1'b0, 24'd0});
		add_row("$GPRMC,235959", 1'b1, "\r\n", 1'b0, '0);
		add_row("$GPRMC,000000.000,A,4807.038,N", 1'b1, "", 1'b0, '0);
		add_row("$GPRMC,12345,A", 1'b1, "", 1'b0, '0);
		add_row("$GPRMC,A12345", 1'b1, "", 1'b0, '0);
		add_row("$GPRMC,0\377\377\377\377\377", 1'b1, "", 1'b0, '0);
		add_row("$GPRMC", 1'b1, "0123\r\n", 1'b0, '0);
		add_row("$GPRMC,1\r23456", 1'b1, "*\r\n", 1'b0, '0);
		add_row("$GPRMC\r,010203", 1'b1, "", 1'b0, '0);
		add_row("$GPRMC,123456", 1'b0, "", 1'b0, '0);
		add_row("$GPGGA,101010", 1'b1, "", 1'b0, '0);
		add_row("$GPRMC,999999*zz", 1'b0, "", 1'b0, '0);
		add_row("#GPRMC,112233", 1'b1, "", 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone NUL right after reset: nothing valid, stored time still clear
		line_q.delete();
		line_q.push_back(8'h00);
		send_line(1'b1, {1'b0, 1'b0, 1'b0, 24'd0});

		for (int r = 0; r < row_head.size(); r++) begin
			line_q.delete();
			push_text(row_head[r]);
			if (row_sum[r]) close_sum(SUM_GOOD);
			push_text(row_tail[r]);
			send_line(row_typed[r], row_exp[r]);
		end
		drain_status();

		while (chars_sent < 500) begin
			make_sentence();
			send_line(1'b0, '0);
			random_lines++;
			if (random_lines % 16 == 0) drain_status();
		end

		drain_status();
		repeat (8) @(posedge clk);
		$display("sent %0d sentences, %0d characters; checked %0d status beats, %0d time updates",
			lines_sent, chars_sent, results, updates);
		if (errors == 0) begin
			$display("[nmea_rmc_checksum_time_parser_top] OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("[nmea_rmc_checksum_time_parser_top] ERROR");
		end
		$finish;
	end

endmodule

// ===== nmea_rmc_checksum_time_parser_top.f =====
design/nrmc_pkg.sv
design/nmea_rmc_checksum_time_parser_top.sv
design/nrmc_chk.sv
tb/tb_nmea_rmc_checksum_time_parser_top.sv
